// File: sv/ppc_pkg.sv
// types and constants shared by the packet protocol classifier
`default_nettype none

package ppc_pkg;

   // header walk position
   typedef enum logic [2:0] {
      LYR_ETH   = 3'd0,
      LYR_PPPOE = 3'd1,
      LYR_IPV4  = 3'd2,
      LYR_IPV6  = 3'd3,
      LYR_HOP   = 3'd4,
      LYR_TCP   = 3'd5,
      LYR_UDP   = 3'd6,
      LYR_DONE  = 3'd7
   } layer_type;

   typedef logic [4:0] class_type;
   typedef logic [5:0] index_type;

   // packet classes
   localparam class_type CLS_UNKNOWN = 5'd0;
   localparam class_type CLS_ARP     = 5'd1;
   localparam class_type CLS_LLC     = 5'd2;
   localparam class_type CLS_IPV4    = 5'd3;
   localparam class_type CLS_IPV6    = 5'd4;
   localparam class_type CLS_PPPOED  = 5'd5;
   localparam class_type CLS_PPPOES  = 5'd6;
   localparam class_type CLS_LCP     = 5'd7;
   localparam class_type CLS_STP     = 5'd8;
   localparam class_type CLS_ICMP    = 5'd9;
   localparam class_type CLS_IGMP    = 5'd10;
   localparam class_type CLS_ICMPV6  = 5'd11;
   localparam class_type CLS_TCP     = 5'd12;
   localparam class_type CLS_UDP     = 5'd13;
   localparam class_type CLS_HTTP    = 5'd14;
   localparam class_type CLS_DNS     = 5'd15;
   localparam class_type CLS_DHCP    = 5'd16;
   localparam class_type CLS_NTP     = 5'd17;
   localparam class_type CLS_NBNS    = 5'd18;
   localparam class_type CLS_DHCPV6  = 5'd19;
   localparam class_type CLS_SSDP    = 5'd20;
   localparam class_type CLS_MDNS    = 5'd21;
   localparam class_type CLS_LLMNR   = 5'd22;
   localparam class_type CLS_QICQ    = 5'd23;

   // ethertypes and ppp protocols
   localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
   localparam logic [15:0] ETYPE_ARP    = 16'h0806;
   localparam logic [15:0] ETYPE_LLC    = 16'h0004;
   localparam logic [15:0] ETYPE_IPV6   = 16'h86dd;
   localparam logic [15:0] ETYPE_PPPOED = 16'h8863;
   localparam logic [15:0] ETYPE_PPPOES = 16'h8864;
   localparam logic [15:0] ETYPE_STP    = 16'h0069;
   localparam logic [15:0] PPP_IPV4     = 16'h0021;
   localparam logic [15:0] PPP_IPV6     = 16'h0057;
   localparam logic [15:0] PPP_LCP      = 16'hc021;

   // ip protocol numbers
   localparam logic [7:0] PROTO_HOP    = 8'h00;
   localparam logic [7:0] PROTO_ICMP   = 8'h01;
   localparam logic [7:0] PROTO_IGMP   = 8'h02;
   localparam logic [7:0] PROTO_TCP    = 8'h06;
   localparam logic [7:0] PROTO_UDP    = 8'h11;
   localparam logic [7:0] PROTO_ICMPV6 = 8'h3a;

   // well-known ports
   localparam logic [15:0] PORT_HTTP     = 16'd80;
   localparam logic [15:0] PORT_DNS      = 16'd53;
   localparam logic [15:0] PORT_DHCP_SRV = 16'd67;
   localparam logic [15:0] PORT_DHCP_CLI = 16'd68;
   localparam logic [15:0] PORT_NTP      = 16'd123;
   localparam logic [15:0] PORT_NBNS     = 16'd137;
   localparam logic [15:0] PORT_DHCPV6_C = 16'd546;
   localparam logic [15:0] PORT_DHCPV6_S = 16'd547;
   localparam logic [15:0] PORT_SSDP     = 16'd1900;
   localparam logic [15:0] PORT_MDNS     = 16'd5353;
   localparam logic [15:0] PORT_LLMNR    = 16'd5355;
   localparam logic [15:0] PORT_QICQ     = 16'd8000;

   // header length in bytes for each layer
   function automatic index_type hdr_len(input layer_type lyr);
      index_type len;
      case (lyr)
         LYR_ETH:   len = 6'd14;
         LYR_PPPOE: len = 6'd8;
         LYR_IPV4:  len = 6'd20;
         LYR_IPV6:  len = 6'd40;
         LYR_HOP:   len = 6'd8;
         LYR_TCP:   len = 6'd20;
         LYR_UDP:   len = 6'd8;
         default:   len = 6'd0;
      endcase
      return len;
   endfunction

   // stp group destination mac 01:80:c2:00:00:00
   function automatic logic [7:0] stp_mac_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0:    b = 8'h01;
         3'd1:    b = 8'h80;
         3'd2:    b = 8'hc2;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

// File: sv/packet_protocol_classifier_unit.sv
// byte-serial packet header parser and protocol classifier
//
//  channel | ports                                      | direction
//  --------+--------------------------------------------+----------
//  request | req_valid req_ready req_data_byte          | in
//          | req_last_byte                              |
//  result  | rsp_valid rsp_ready rsp_packet_class       | out
//          | rsp_broken                                 |
//
// One request byte per cycle: each byte updates the parser state registers
// directly, and the byte marked last loads the result register in the same cycle.
// A result appears in the cycle after its last byte is taken. The request side stalls only
// while a result is held and rsp_ready is low.
// Synchronous reset returns the parser to the start of an Ethernet header.
`default_nettype none

module packet_protocol_classifier_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_last_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [4:0]      rsp_packet_class,
   output logic            rsp_broken
);

   // parser state
   ppc_pkg::index_type byte_idx_ff, byte_idx_in;
   ppc_pkg::layer_type layer_ff, layer_in;
   logic [15:0]        type_ff, type_in;
   logic               stp_ff, stp_in;
   logic [7:0]         proto_ff, proto_in;
   logic               hop_ff, hop_in;
   logic [15:0]        sport_ff, sport_in;
   logic [15:0]        dport_ff, dport_in;
   ppc_pkg::class_type class_ff, class_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   ppc_pkg::class_type rsp_class_ff, rsp_class_in;
   logic               rsp_broken_ff, rsp_broken_in;

   // working values after taking the byte
   logic               req_fire;
   ppc_pkg::index_type idx_inc;
   logic [15:0]        type_w, sport_w, dport_w;
   logic [7:0]         proto_w;
   logic               stp_w;
   ppc_pkg::index_type idx_w;
   ppc_pkg::layer_type layer_w;
   ppc_pkg::class_type class_w;
   logic               hop_w;
   ppc_pkg::class_type port_cls;

   // tcp service by port
   function automatic ppc_pkg::class_type tcp_cls(input logic [15:0] p);
      ppc_pkg::class_type c;
      if (p == ppc_pkg::PORT_HTTP) c = ppc_pkg::CLS_HTTP;
      else if (p == ppc_pkg::PORT_DNS) c = ppc_pkg::CLS_DNS;
      else c = ppc_pkg::CLS_UNKNOWN;
      return c;
   endfunction

   // udp service by destination port
   function automatic ppc_pkg::class_type udp_dst_cls(input logic [15:0] p);
      ppc_pkg::class_type c;
      case (p)
         ppc_pkg::PORT_DHCP_SRV, ppc_pkg::PORT_DHCP_CLI: c = ppc_pkg::CLS_DHCP;
         ppc_pkg::PORT_NTP:                             c = ppc_pkg::CLS_NTP;
         ppc_pkg::PORT_NBNS:                            c = ppc_pkg::CLS_NBNS;
         ppc_pkg::PORT_DHCPV6_C, ppc_pkg::PORT_DHCPV6_S: c = ppc_pkg::CLS_DHCPV6;
         ppc_pkg::PORT_SSDP:                            c = ppc_pkg::CLS_SSDP;
         ppc_pkg::PORT_MDNS:                            c = ppc_pkg::CLS_MDNS;
         ppc_pkg::PORT_LLMNR:                           c = ppc_pkg::CLS_LLMNR;
         ppc_pkg::PORT_QICQ:                            c = ppc_pkg::CLS_QICQ;
         default:                                       c = ppc_pkg::CLS_UNKNOWN;
      endcase
      return c;
   endfunction

   // udp service by source port
   function automatic ppc_pkg::class_type udp_src_cls(input logic [15:0] p);
      ppc_pkg::class_type c;
      if (p == ppc_pkg::PORT_DHCP_SRV || p == ppc_pkg::PORT_DHCP_CLI) c = ppc_pkg::CLS_DHCP;
      else if (p == ppc_pkg::PORT_QICQ) c = ppc_pkg::CLS_QICQ;
      else c = ppc_pkg::CLS_UNKNOWN;
      return c;
   endfunction

   // handshake
   assign req_fire  = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_packet_class = rsp_class_ff;
   assign rsp_broken       = rsp_broken_ff;

   // capture fields of the current header
   always_comb begin
      type_w  = type_ff;
      proto_w = proto_ff;
      sport_w = sport_ff;
      dport_w = dport_ff;
      stp_w   = stp_ff;
      case (layer_ff)
         ppc_pkg::LYR_ETH: begin
            if (byte_idx_ff < 6'd6 && req_data_byte != ppc_pkg::stp_mac_byte(byte_idx_ff[2:0]))
               stp_w = 1'b0;
            if (byte_idx_ff == 6'd12) type_w = {req_data_byte, 8'h00};
            if (byte_idx_ff == 6'd13) type_w = {type_ff[15:8], req_data_byte};
         end
         ppc_pkg::LYR_PPPOE: begin
            if (byte_idx_ff == 6'd6) type_w = {req_data_byte, 8'h00};
            if (byte_idx_ff == 6'd7) type_w = {type_ff[15:8], req_data_byte};
         end
         ppc_pkg::LYR_IPV4: begin
            if (byte_idx_ff == 6'd9) proto_w = req_data_byte;
         end
         ppc_pkg::LYR_IPV6: begin
            if (byte_idx_ff == 6'd6) proto_w = req_data_byte;
         end
         ppc_pkg::LYR_HOP: begin
            if (byte_idx_ff == 6'd0) proto_w = req_data_byte;
         end
         ppc_pkg::LYR_TCP, ppc_pkg::LYR_UDP: begin
            if (byte_idx_ff == 6'd0) sport_w = {req_data_byte, 8'h00};
            if (byte_idx_ff == 6'd1) sport_w = {sport_ff[15:8], req_data_byte};
            if (byte_idx_ff == 6'd2) dport_w = {req_data_byte, 8'h00};
            if (byte_idx_ff == 6'd3) dport_w = {dport_ff[15:8], req_data_byte};
         end
         default: begin
         end
      endcase
   end

   // transport class, destination port first
   always_comb begin
      if (layer_ff == ppc_pkg::LYR_TCP) begin
         port_cls = tcp_cls(dport_w);
         if (port_cls == ppc_pkg::CLS_UNKNOWN) port_cls = tcp_cls(sport_w);
         if (port_cls == ppc_pkg::CLS_UNKNOWN) port_cls = ppc_pkg::CLS_TCP;
      end else begin
         port_cls = udp_dst_cls(dport_w);
         if (port_cls == ppc_pkg::CLS_UNKNOWN) port_cls = udp_src_cls(sport_w);
         if (port_cls == ppc_pkg::CLS_UNKNOWN) port_cls = ppc_pkg::CLS_UDP;
      end
   end

   // advance within header, classify at its end
   assign idx_inc = byte_idx_ff + 6'd1;

   always_comb begin
      idx_w   = byte_idx_ff;
      layer_w = layer_ff;
      class_w = class_ff;
      hop_w   = hop_ff;
      if (layer_ff != ppc_pkg::LYR_DONE) begin
         if (idx_inc < ppc_pkg::hdr_len(layer_ff)) begin
            idx_w = idx_inc;
         end else begin
            idx_w = 6'd0;
            case (layer_ff)
               ppc_pkg::LYR_ETH: begin
                  layer_w = ppc_pkg::LYR_DONE;
                  case (type_w)
                     ppc_pkg::ETYPE_IPV4: begin
                        class_w = ppc_pkg::CLS_IPV4;
                        layer_w = ppc_pkg::LYR_IPV4;
                     end
                     ppc_pkg::ETYPE_ARP:    class_w = ppc_pkg::CLS_ARP;
                     ppc_pkg::ETYPE_LLC:    class_w = ppc_pkg::CLS_LLC;
                     ppc_pkg::ETYPE_IPV6: begin
                        class_w = ppc_pkg::CLS_IPV6;
                        layer_w = ppc_pkg::LYR_IPV6;
                     end
                     ppc_pkg::ETYPE_PPPOED: class_w = ppc_pkg::CLS_PPPOED;
                     ppc_pkg::ETYPE_PPPOES: begin
                        class_w = ppc_pkg::CLS_PPPOES;
                        layer_w = ppc_pkg::LYR_PPPOE;
                     end
                     ppc_pkg::ETYPE_STP:
                        class_w = stp_w ? ppc_pkg::CLS_STP : ppc_pkg::CLS_UNKNOWN;
                     default:               class_w = ppc_pkg::CLS_UNKNOWN;
                  endcase
               end
               ppc_pkg::LYR_PPPOE: begin
                  layer_w = ppc_pkg::LYR_DONE;
                  case (type_w)
                     ppc_pkg::PPP_IPV4: begin
                        class_w = ppc_pkg::CLS_IPV4;
                        layer_w = ppc_pkg::LYR_IPV4;
                     end
                     ppc_pkg::PPP_IPV6: begin
                        class_w = ppc_pkg::CLS_IPV6;
                        layer_w = ppc_pkg::LYR_IPV6;
                     end
                     ppc_pkg::PPP_LCP: class_w = ppc_pkg::CLS_LCP;
                     default:          class_w = ppc_pkg::CLS_PPPOES;
                  endcase
               end
               ppc_pkg::LYR_IPV4: begin
                  layer_w = ppc_pkg::LYR_DONE;
                  case (proto_w)
                     ppc_pkg::PROTO_ICMP: class_w = ppc_pkg::CLS_ICMP;
                     ppc_pkg::PROTO_IGMP: class_w = ppc_pkg::CLS_IGMP;
                     ppc_pkg::PROTO_TCP: begin
                        class_w = ppc_pkg::CLS_TCP;
                        layer_w = ppc_pkg::LYR_TCP;
                     end
                     ppc_pkg::PROTO_UDP: begin
                        class_w = ppc_pkg::CLS_UDP;
                        layer_w = ppc_pkg::LYR_UDP;
                     end
                     default:             class_w = ppc_pkg::CLS_IPV4;
                  endcase
               end
               ppc_pkg::LYR_IPV6, ppc_pkg::LYR_HOP: begin
                  layer_w = ppc_pkg::LYR_DONE;
                  case (proto_w)
                     // one hop-by-hop header is skipped, a second one ends the walk
                     ppc_pkg::PROTO_HOP: begin
                        class_w = ppc_pkg::CLS_IPV6;
                        if (!hop_ff) begin
                           hop_w   = 1'b1;
                           layer_w = ppc_pkg::LYR_HOP;
                        end
                     end
                     ppc_pkg::PROTO_ICMPV6: class_w = ppc_pkg::CLS_ICMPV6;
                     ppc_pkg::PROTO_TCP: begin
                        class_w = ppc_pkg::CLS_TCP;
                        layer_w = ppc_pkg::LYR_TCP;
                     end
                     ppc_pkg::PROTO_UDP: begin
                        class_w = ppc_pkg::CLS_UDP;
                        layer_w = ppc_pkg::LYR_UDP;
                     end
                     default:               class_w = ppc_pkg::CLS_IPV6;
                  endcase
               end
               default: begin
                  class_w = port_cls;
                  layer_w = ppc_pkg::LYR_DONE;
               end
            endcase
         end
      end
   end

   // next state: hold, advance, or restart after the last byte
   always_comb begin
      byte_idx_in   = byte_idx_ff;
      layer_in      = layer_ff;
      type_in       = type_ff;
      stp_in        = stp_ff;
      proto_in      = proto_ff;
      hop_in        = hop_ff;
      sport_in      = sport_ff;
      dport_in      = dport_ff;
      class_in      = class_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_class_in  = rsp_class_ff;
      rsp_broken_in = rsp_broken_ff;
      if (req_fire) begin
         if (req_last_byte) begin
            rsp_valid_in  = 1'b1;
            rsp_class_in  = class_w;
            rsp_broken_in = (layer_w != ppc_pkg::LYR_DONE) && (idx_w != 6'd0);
            byte_idx_in   = 6'd0;
            layer_in      = ppc_pkg::LYR_ETH;
            type_in       = 16'h0000;
            stp_in        = 1'b1;
            proto_in      = 8'h00;
            hop_in        = 1'b0;
            sport_in      = 16'h0000;
            dport_in      = 16'h0000;
            class_in      = ppc_pkg::CLS_UNKNOWN;
         end else begin
            byte_idx_in = idx_w;
            layer_in    = layer_w;
            type_in     = type_w;
            stp_in      = stp_w;
            proto_in    = proto_w;
            hop_in      = hop_w;
            sport_in    = sport_w;
            dport_in    = dport_w;
            class_in    = class_w;
         end
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_idx_ff  <= 6'd0;
         layer_ff     <= ppc_pkg::LYR_ETH;
         type_ff      <= 16'h0000;
         stp_ff       <= 1'b1;
         proto_ff     <= 8'h00;
         hop_ff       <= 1'b0;
         sport_ff     <= 16'h0000;
         dport_ff     <= 16'h0000;
         class_ff     <= ppc_pkg::CLS_UNKNOWN;
         rsp_valid_ff <= 1'b0;
      end else begin
         byte_idx_ff  <= byte_idx_in;
         layer_ff     <= layer_in;
         type_ff      <= type_in;
         stp_ff       <= stp_in;
         proto_ff     <= proto_in;
         hop_ff       <= hop_in;
         sport_ff     <= sport_in;
         dport_ff     <= dport_in;
         class_ff     <= class_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_class_ff  <= rsp_class_in;
      rsp_broken_ff <= rsp_broken_in;
   end

endmodule

`default_nettype wire
